/* sv/state_variable_filter_step_macros.svh */
// assertion macros for the state variable filter checker
`ifndef STATE_VARIABLE_FILTER_STEP_MACROS_SVH
`define STATE_VARIABLE_FILTER_STEP_MACROS_SVH

// same-cycle implication
`define SVF_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");

// next-cycle implication
`define SVF_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");

// next-cycle check that also runs during reset
`define SVF_ASSERT_ALWAYS(lbl, a, c) \
  lbl: assert property (@(posedge clk) (a) |=> (c)) else $error("lbl");

`endif

/* sv/svf_pkg.sv */
// shared types, constants and step table for the state variable filter
`default_nettype none
package svf_pkg;

  localparam int COEF_FRAC_BITS_DEF = 40;
  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int STATE_BITS_DEF     = 48;
  localparam int OUT_BITS           = 24;
  localparam int DIG_W              = 4;
  localparam int SH_W               = 7;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 13;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRUCT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BSHIFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RMODES   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTRND   = 3'd6;

  localparam logic [2:0] RND_FLOOR     = 3'd0;
  localparam logic [2:0] RND_ZERO      = 3'd1;
  localparam logic [2:0] RND_HALF_AWAY = 3'd2;
  localparam logic [2:0] RND_HALF_UP   = 3'd3;

  localparam logic [1:0] STRUCT_SEP    = 2'd0;
  localparam logic [1:0] STRUCT_SINGLE = 2'd1;
  localparam logic [1:0] STRUCT_DMUL   = 2'd2;
  localparam logic [1:0] STRUCT_DSEP   = 2'd3;

  localparam logic [7:0] DAMP_TABLE [32] = '{
    8'd192, 8'd176, 8'd160, 8'd144, 8'd128, 8'd120, 8'd112, 8'd104,
    8'd96,  8'd88,  8'd80,  8'd72,  8'd64,  8'd60,  8'd56,  8'd52,
    8'd48,  8'd44,  8'd40,  8'd36,  8'd32,  8'd30,  8'd28,  8'd26,
    8'd24,  8'd22,  8'd20,  8'd18,  8'd16,  8'd15,  8'd14,  8'd13};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_COEF  = 7'b0000010,
    S_DAMP  = 7'b0000100,
    S_NEXT  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_RND   = 7'b0100000,
    S_APPLY = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {OP_RND, OP_ACC, OP_FOLD, OP_LOW, OP_OUT} op_t;
  typedef enum logic [1:0] {A_F, A_FQ, A_D} asel_t;
  typedef enum logic [1:0] {B_X8, B_LOW, B_BAND, B_NB} bsel_t;
  typedef enum logic [2:0] {SH_X, SH_L, SH_S, SH_F, SH_INT, LS_X, LS_L, LS_8} sh_t;
  typedef enum logic [1:0] {RM_IN, RM_LOW, RM_DAMP, RM_INT} rsel_t;

  typedef struct packed {
    op_t   op;
    asel_t a;
    bsel_t b;
    logic  neg;
    sh_t   sh;
    rsel_t rm;
  } step_t;

  typedef struct packed {
    logic [SH_W-1:0] sh;
    logic [2:0]      mode;
  } rnd_ctl_t;

  function automatic step_t mk(input op_t op, input asel_t a, input bsel_t b,
                               input logic neg, input sh_t sh, input rsel_t rm);
    step_t s;
    s.op  = op;
    s.a   = a;
    s.b   = b;
    s.neg = neg;
    s.sh  = sh;
    s.rm  = rm;
    return s;
  endfunction

  function automatic step_t step_decode(input logic [1:0] structure, input logic [2:0] step);
    step_t s_low;
    step_t s_out;
    step_t s;
    s_low = mk(OP_LOW, A_F, B_NB, 1'b0, SH_INT, RM_INT);
    s_out = mk(OP_OUT, A_F, B_NB, 1'b0, SH_INT, RM_INT);
    s = s_out;
    case (structure)
      STRUCT_SEP: begin
        case (step)
          3'd0: s = mk(OP_RND, A_F, B_X8, 1'b0, SH_X, RM_IN);
          3'd1: s = mk(OP_RND, A_F, B_LOW, 1'b1, SH_L, RM_LOW);
          3'd2: s = mk(OP_RND, A_FQ, B_BAND, 1'b1, SH_S, RM_DAMP);
          3'd3: s = s_low;
          default: s = s_out;
        endcase
      end
      STRUCT_SINGLE: begin
        case (step)
          3'd0: s = mk(OP_ACC, A_F, B_X8, 1'b0, LS_X, RM_IN);
          3'd1: s = mk(OP_ACC, A_F, B_LOW, 1'b1, LS_L, RM_IN);
          3'd2: s = mk(OP_ACC, A_FQ, B_BAND, 1'b1, LS_8, RM_IN);
          3'd3: s = mk(OP_FOLD, A_F, B_NB, 1'b0, SH_F, RM_IN);
          3'd4: s = s_low;
          default: s = s_out;
        endcase
      end
      STRUCT_DMUL: begin
        case (step)
          3'd0: s = mk(OP_ACC, A_F, B_X8, 1'b0, LS_X, RM_IN);
          3'd1: s = mk(OP_ACC, A_F, B_LOW, 1'b1, LS_L, RM_IN);
          3'd2: s = mk(OP_RND, A_D, B_BAND, 1'b0, SH_S, RM_DAMP);
          3'd3: s = mk(OP_FOLD, A_F, B_NB, 1'b0, SH_F, RM_IN);
          3'd4: s = s_low;
          default: s = s_out;
        endcase
      end
      default: begin
        case (step)
          3'd0: s = mk(OP_RND, A_D, B_BAND, 1'b0, SH_S, RM_DAMP);
          3'd1: s = mk(OP_RND, A_F, B_X8, 1'b0, SH_X, RM_IN);
          3'd2: s = mk(OP_RND, A_F, B_LOW, 1'b1, SH_L, RM_LOW);
          3'd3: s = s_low;
          default: s = s_out;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/svf_mul.sv */
// digit-serial signed multiplier, one 4-bit digit of b per cycle, msb first
`default_nettype none
module svf_mul
  import svf_pkg::*;
#(
  parameter int AW = COEF_FRAC_BITS_DEF + 2,
  parameter int BW = STATE_BITS_DEF,
  localparam int NDIG = (BW + DIG_W - 1) / DIG_W,
  localparam int PW = AW + NDIG * DIG_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic                 done,
  output logic signed [PW-1:0] p
);

  localparam int BP = NDIG * DIG_W;
  localparam int CW = $clog2(NDIG + 1);

  logic signed [AW-1:0]      areg;
  logic [BP-1:0]             breg;
  logic signed [PW-1:0]      acc;
  logic [CW-1:0]             cnt;
  logic                      first;
  logic                      busy;
  logic [DIG_W-1:0]          dig;
  logic signed [DIG_W:0]     sdig;
  logic signed [AW+DIG_W:0]  part;

  always_comb begin
    dig  = breg[BP-1 -: DIG_W];
    sdig = {first & dig[DIG_W-1], dig};
    part = (AW+DIG_W+1)'(areg) * (AW+DIG_W+1)'(sdig);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        areg  <= a;
        breg  <= BP'(b);
        acc   <= '0;
        cnt   <= CW'(NDIG);
        first <= 1'b1;
        busy  <= 1'b1;
      end else if (busy) begin
        acc   <= (acc <<< DIG_W) + PW'(part);
        breg  <= breg << DIG_W;
        cnt   <= cnt - 1'b1;
        first <= 1'b0;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign p = acc;

endmodule
`default_nettype wire

/* sv/svf_rnd.sv */
// rounding right shift with five rounding modes
`default_nettype none
module svf_rnd
  import svf_pkg::*;
#(
  parameter int W = STATE_BITS_DEF
) (
  input  logic signed [W-1:0] v,
  input  rnd_ctl_t            ctl,
  output logic signed [W:0]   r
);

  logic [W:0]        one;
  logic [W:0]        mask;
  logic [W:0]        half;
  logic [W:0]        bias;
  logic signed [W:0] sum;
  logic              neg;

  always_comb begin
    one  = (W+1)'(1);
    mask = (one << ctl.sh) - one;
    half = mask - (mask >> 1);
    neg  = v[W-1];
    case (ctl.mode)
      RND_FLOOR:     bias = '0;
      RND_ZERO:      bias = neg ? mask : '0;
      RND_HALF_AWAY: bias = neg ? (mask >> 1) : half;
      RND_HALF_UP:   bias = half;
      default:       bias = mask;
    endcase
    sum = (W+1)'(v) + $signed(bias);
    r   = sum >>> ctl.sh;
  end

endmodule
`default_nettype wire

/* sv/state_variable_filter_step.sv */
// top level of the fixed-point state variable low-pass filter
// a transaction passes S_COEF and S_DAMP for the coefficients, then one product on the
//   digit-serial multiplier per step, a fold for structures 1 and 2 only, and the output step
// one sample is processed at a time; a new sample is taken once the result
//   sits in the output register, and a stalled result holds the next one at its last step
// reset: synchronous, clears state, configuration and handshake flags
`default_nettype none
module state_variable_filter_step
  import svf_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int STATE_BITS     = STATE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_BITS-1:0]   filtered,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int AW   = COEF_FRAC_BITS + 2;
  localparam int NDIG = (STATE_BITS + DIG_W - 1) / DIG_W;
  localparam int PW   = AW + NDIG * DIG_W;
  localparam int WW   = PW + 14;
  localparam int OW   = STATE_BITS + 1;
  localparam int XW   = SAMPLE_BITS + 3;

  localparam logic signed [WW-1:0] ST_MAX =
    {{(WW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [WW-1:0] ST_MIN =
    {{(WW-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [OW-1:0] OUT_MAX =
    {{(OW-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN =
    {{(OW-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

  logic [12:0]      freq_code;
  logic [4:0]       q_index;
  logic [1:0]       structure;
  logic [1:0]       low_hidden_bits;
  logic signed [2:0] band_scale_shift;
  logic [11:0]      round_modes;
  logic [2:0]       output_round_mode;

  state_t                  state;
  logic [2:0]              step;
  logic signed [AW-1:0]    f_r;
  logic signed [AW-1:0]    fq_r;
  logic signed [AW-1:0]    d_r;
  logic signed [XW-1:0]    x8;
  logic signed [STATE_BITS-1:0] low_acc;
  logic signed [STATE_BITS-1:0] band_acc;
  logic signed [WW-1:0]    nb;
  logic signed [WW-1:0]    t;
  logic signed [WW-1:0]    rreg;

  step_t                   st;
  logic [AW-1:0]           f_comb;
  logic [AW+7:0]           fq_full;
  logic signed [AW-1:0]    a_mux;
  logic signed [STATE_BITS-1:0] b_mux;
  logic signed [STATE_BITS-1:0] nb_sat;
  logic signed [SH_W:0]    hb_s;
  logic signed [SH_W:0]    hl_s;
  logic signed [SH_W:0]    s_c;
  logic signed [SH_W:0]    sh_full;
  logic [2:0]              mode_sel;
  rnd_ctl_t                main_ctl;
  rnd_ctl_t                out_ctl;
  logic                    mul_start;
  logic                    mul_done;
  logic signed [PW-1:0]    prod;
  logic signed [WW-1:0]    src;
  logic signed [WW:0]      rnd_main;
  logic signed [OW-1:0]    rnd_out;
  logic signed [OW-1:0]    y_w;
  logic signed [OUT_BITS-1:0] y_sat;
  logic signed [WW-1:0]    low_sum;

  function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [WW-1:0] v);
    if (v > ST_MAX) return ST_MAX[STATE_BITS-1:0];
    if (v < ST_MIN) return ST_MIN[STATE_BITS-1:0];
    return v[STATE_BITS-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign st        = step_decode(structure, step);

  always_comb begin
    f_comb  = (AW'({1'b1, freq_code[8:1]}) << (COEF_FRAC_BITS - 24)) << freq_code[12:9];
    fq_full = (AW+8)'(f_r) * (AW+8)'(DAMP_TABLE[q_index]);
    case (st.a)
      A_FQ:    a_mux = fq_r;
      A_D:     a_mux = d_r;
      default: a_mux = f_r;
    endcase
    nb_sat = sat_st(nb);
    case (st.b)
      B_X8:    b_mux = STATE_BITS'(x8);
      B_LOW:   b_mux = low_acc;
      B_BAND:  b_mux = band_acc;
      default: b_mux = nb_sat;
    endcase
    hb_s = (SH_W+1)'(band_scale_shift);
    hl_s = (SH_W+1)'(low_hidden_bits);
    s_c  = (SH_W+1)'(COEF_FRAC_BITS);
    case (st.sh)
      SH_X:    sh_full = s_c - hb_s;
      SH_L:    sh_full = s_c - hb_s + hl_s;
      SH_S:    sh_full = s_c;
      SH_F:    sh_full = s_c + (SH_W+1)'(8);
      SH_INT:  sh_full = s_c - hl_s + hb_s;
      LS_X:    sh_full = hb_s + (SH_W+1)'(8);
      LS_L:    sh_full = hb_s - hl_s + (SH_W+1)'(8);
      default: sh_full = (SH_W+1)'(8);
    endcase
    case (st.rm)
      RM_IN:   mode_sel = round_modes[2:0];
      RM_LOW:  mode_sel = round_modes[5:3];
      RM_DAMP: mode_sel = round_modes[8:6];
      default: mode_sel = round_modes[11:9];
    endcase
    main_ctl.sh   = sh_full[SH_W-1:0];
    main_ctl.mode = mode_sel;
    out_ctl.sh    = SH_W'(low_hidden_bits);
    out_ctl.mode  = output_round_mode;
    src     = (st.op == OP_FOLD) ? t : WW'(prod);
    low_sum = WW'(low_acc) + rreg;
    y_w     = rnd_out;
    if (y_w > OUT_MAX) y_sat = OUT_MAX[OUT_BITS-1:0];
    else if (y_w < OUT_MIN) y_sat = OUT_MIN[OUT_BITS-1:0];
    else y_sat = y_w[OUT_BITS-1:0];
    mul_start = (state == S_NEXT) && (st.op != OP_OUT) && (st.op != OP_FOLD);
  end

  svf_mul #(.AW(AW), .BW(STATE_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (a_mux),
    .b     (b_mux),
    .done  (mul_done),
    .p     (prod)
  );

  svf_rnd #(.W(WW)) u_rnd_main (
    .v   (src),
    .ctl (main_ctl),
    .r   (rnd_main)
  );

  svf_rnd #(.W(STATE_BITS)) u_rnd_out (
    .v   (low_acc),
    .ctl (out_ctl),
    .r   (rnd_out)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_code         <= '0;
      q_index           <= '0;
      structure         <= '0;
      low_hidden_bits   <= '0;
      band_scale_shift  <= '0;
      round_modes       <= '0;
      output_round_mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FREQ:   freq_code         <= cfg_data[12:0];
        REG_Q:      q_index           <= cfg_data[4:0];
        REG_STRUCT: structure         <= cfg_data[1:0];
        REG_HIDDEN: low_hidden_bits   <= cfg_data[1:0];
        REG_BSHIFT: band_scale_shift  <= cfg_data[2:0];
        REG_RMODES: round_modes       <= cfg_data[11:0];
        REG_OUTRND: output_round_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      low_acc   <= '0;
      band_acc  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !(state == S_NEXT && st.op == OP_OUT)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x8    <= XW'(sample) <<< 3;
            nb    <= structure[1] ? '0 : WW'(band_acc);
            t     <= '0;
            step  <= '0;
            f_r   <= f_comb;
            state <= S_COEF;
          end
        end
        S_COEF: begin
          fq_r  <= fq_full[AW+6:7];
          state <= S_DAMP;
        end
        S_DAMP: begin
          d_r   <= (AW'(1) << COEF_FRAC_BITS) - fq_r;
          state <= S_NEXT;
        end
        S_NEXT: begin
          case (st.op)
            OP_OUT: begin
              if (!out_valid || out_ready) begin
                filtered  <= y_sat;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end
            OP_FOLD: state <= S_RND;
            OP_LOW: begin
              band_acc <= nb_sat;
              state    <= S_MUL;
            end
            default: state <= S_MUL;
          endcase
        end
        S_MUL: begin
          if (mul_done) state <= S_RND;
        end
        S_RND: begin
          rreg  <= (st.op == OP_ACC) ? (src <<< sh_full[SH_W-1:0]) : rnd_main[WW-1:0];
          state <= S_APPLY;
        end
        S_APPLY: begin
          case (st.op)
            OP_ACC:  t <= st.neg ? t - rreg : t + rreg;
            OP_LOW:  low_acc <= sat_st(low_sum);
            default: nb <= st.neg ? nb - rreg : nb + rreg;
          endcase
          step  <= step + 3'd1;
          state <= S_NEXT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/svf_chk.sv */
// port-level checker for the state variable filter, bound to the top level
`default_nettype none
`include "state_variable_filter_step_macros.svh"
module svf_chk
  import svf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OUT_BITS-1:0]    filtered,
  input logic                   cfg_ready
);

  // an accepted transaction keeps the input side busy in the next cycle
  `SVF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a result that is not taken stays put
  `SVF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered))
  // no result straight out of reset
  `SVF_ASSERT_ALWAYS(a_reset_quiet, rst, !out_valid)
  // a new result needs an earlier input transaction, never on the accept edge
  `SVF_ASSERT_NOW(a_no_instant_result, $rose(out_valid), !$past(in_valid && in_ready))
  // configuration is always taken
  `SVF_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind state_variable_filter_step svf_chk u_svf_chk (.*);
`default_nettype wire
